/* hdl/krt_pkg.sv */
`default_nettype none
package krt_pkg;

  // table capacity and derived widths
  localparam int ROUTE_SLOTS = 16;
  localparam int IDX_W       = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(ROUTE_SLOTS + 1);

  // request codes
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_BAD_PHY   = 2'd3;

  // cell operations
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_APPEND = 2'd2;
  localparam logic [1:0] OP_SHIFT  = 2'd3;

  // one route entry as held by a cell
  typedef struct packed {
    logic [15:0] key;
    logic [7:0]  phy;
    logic [15:0] frame;
    logic [31:0] rate;
    logic [7:0]  metric;
  } route_entry_t;

  // command broadcast from the controller to every cell
  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] slot;
    route_entry_t     data;
  } cell_ctl_t;

endpackage
`default_nettype wire

/* hdl/krt_if.sv */
`default_nettype none
// request channel
interface krt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] route_key;
  logic [7:0]  phy_port;
  logic [15:0] max_frame;
  logic [31:0] read_rate;
  logic [7:0]  route_metric;

  modport source (output valid, req_type, route_key, phy_port, max_frame, read_rate,
                  route_metric, input ready);
  modport sink   (input valid, req_type, route_key, phy_port, max_frame, read_rate,
                  route_metric, output ready);
endinterface

// response channel
interface krt_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] slot_index;
  logic [4:0] entry_count;

  modport source (output valid, status, slot_index, entry_count, input ready);
  modport sink   (input valid, status, slot_index, entry_count, output ready);
endinterface
`default_nettype wire

/* hdl/krt_cell.sv */
`default_nettype none
module krt_cell
  import krt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic [IDX_W-1:0]    cell_idx,
  input  wire logic [CNT_W-1:0]    count,
  input  wire logic [15:0]         cmp_key,
  input  wire cell_ctl_t           ctl,
  input  wire route_entry_t        shift_in,
  output route_entry_t             entry,
  output logic                     hit
);

  route_entry_t entry_r;
  route_entry_t entry_nxt;
  logic         in_use;

  // only cells below the fill count take part in a lookup
  assign in_use = (CNT_W'(cell_idx) < count);
  assign hit    = in_use && (entry_r.key == cmp_key);
  assign entry  = entry_r;

  // update, append or take the right neighbor's entry
  always_comb begin
    entry_nxt = entry_r;
    case (ctl.op)
      OP_UPDATE: begin
        if (cell_idx == ctl.slot) begin
          entry_nxt.phy    = ctl.data.phy;
          entry_nxt.frame  = ctl.data.frame;
          entry_nxt.rate   = ctl.data.rate;
          entry_nxt.metric = ctl.data.metric;
        end
      end
      OP_APPEND: begin
        if (cell_idx == ctl.slot) entry_nxt = ctl.data;
      end
      OP_SHIFT: begin
        if (cell_idx >= ctl.slot) entry_nxt = shift_in;
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
`default_nettype wire

/* hdl/krt_ctrl.sv */
`default_nettype none
module krt_ctrl
  import krt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  krt_req_if.sink                     req,
  krt_rsp_if.source                   rsp,
  input  wire logic [ROUTE_SLOTS-1:0] hit_vec,
  output logic [CNT_W-1:0]            count,
  output cell_ctl_t                   ctl
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_APPLY = 1'b1;

  logic                   state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [ROUTE_SLOTS-1:0] hit_r;
  logic [1:0]             type_r;
  route_entry_t           data_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             status_r, status_nxt;
  logic [3:0]             slot_r, slot_nxt;
  logic [4:0]             cnt_out_r, cnt_out_nxt;

  logic                   accept;
  logic                   fire;
  logic                   found;
  logic [IDX_W-1:0]       hit_idx;
  logic [IDX_W-1:0]       slot_sel;
  logic [IDX_W+3:0]       slot_wide;
  logic [CNT_W+4:0]       cnt_wide;

  // hit vector is one-hot or empty: keys are unique among valid entries
  function automatic logic [IDX_W-1:0] onehot_index(input logic [ROUTE_SLOTS-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < ROUTE_SLOTS; i++) begin
      if (v[i]) idx = idx | IDX_W'(i);
    end
    return idx;
  endfunction

  assign req.ready = (state_r == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign fire      = (state_r == S_APPLY) && (!out_valid_r || rsp.ready);
  assign found     = |hit_r;
  assign hit_idx   = onehot_index(hit_r);
  assign count     = count_r;

  // decide the outcome of the held request
  always_comb begin
    ctl.op     = OP_HOLD;
    ctl.slot   = hit_idx;
    ctl.data   = data_r;
    status_nxt = ST_OK;
    slot_sel   = '0;
    count_nxt  = count_r;
    case (type_r)
      REQ_ADD: begin
        if (data_r.phy == 8'd0) begin
          status_nxt = ST_BAD_PHY;
        end else if (found) begin
          ctl.op   = OP_UPDATE;
          slot_sel = hit_idx;
        end else if (count_r == CNT_W'(ROUTE_SLOTS)) begin
          status_nxt = ST_FULL;
        end else begin
          ctl.op    = OP_APPEND;
          ctl.slot  = count_r[IDX_W-1:0];
          slot_sel  = count_r[IDX_W-1:0];
          count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_REMOVE: begin
        if (found) begin
          ctl.op    = OP_SHIFT;
          slot_sel  = hit_idx;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      REQ_CLEAR: count_nxt = '0;
      default:   count_nxt = count_r;
    endcase
    if (!fire) ctl.op = OP_HOLD;
  end

  // fit slot and count to the response field widths
  assign slot_wide   = {4'b0, slot_sel};
  assign cnt_wide    = {5'b0, count_nxt};
  assign slot_nxt    = slot_wide[3:0];
  assign cnt_out_nxt = cnt_wide[4:0];

  // sequencing and response register
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (rsp.ready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_APPLY;
      S_APPLY: if (fire) begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) count_r <= count_nxt;
    end
  end

  // request capture and lookup result from the cell row
  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r       <= hit_vec;
      type_r      <= req.req_type;
      data_r.key  <= req.route_key;
      data_r.phy  <= req.phy_port;
      data_r.frame  <= req.max_frame;
      data_r.rate   <= req.read_rate;
      data_r.metric <= req.route_metric;
    end
    if (fire) begin
      status_r  <= status_nxt;
      slot_r    <= slot_nxt;
      cnt_out_r <= cnt_out_nxt;
    end
  end

  assign rsp.valid       = out_valid_r;
  assign rsp.status      = status_r;
  assign rsp.slot_index  = slot_r;
  assign rsp.entry_count = cnt_out_r;

endmodule
`default_nettype wire

/* hdl/keyed_route_table_core.sv */
// Ordered route table of ROUTE_SLOTS entries held in a row of cells, one route per
// cell. In the cycle a request is accepted every cell compares its key with the
// requested route key; the request then moves to the apply state, where the row updates
// one cell, appends at the fill point or shifts the entries behind a removed one down by
// one neighbor. The next request is accepted only once the block is back in idle, so
// requests never overlap; a response that is not taken waits in the output register
// and holds only the following request in the apply state. The table is empty after
// reset with no clearing pass; a clear request empties it in one request.
`default_nettype none
module keyed_route_table_core
  import krt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  krt_req_if.sink    in_req,
  krt_rsp_if.source  out_rsp
);

  logic [ROUTE_SLOTS-1:0] hit_vec;
  logic [CNT_W-1:0]       count;
  cell_ctl_t              ctl;
  route_entry_t           entries [ROUTE_SLOTS];

  krt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (in_req),
    .rsp     (out_rsp),
    .hit_vec (hit_vec),
    .count   (count),
    .ctl     (ctl)
  );

  // cell row, each cell shifts in from its right neighbor, the last cell from itself
  for (genvar i = 0; i < ROUTE_SLOTS; i++) begin : g_cell
    route_entry_t nbr;
    if (i == ROUTE_SLOTS - 1) begin : g_last
      assign nbr = entries[i];
    end else begin : g_mid
      assign nbr = entries[i+1];
    end
    krt_cell u_cell (
      .clk      (clk),
      .cell_idx (IDX_W'(i)),
      .count    (count),
      .cmp_key  (in_req.route_key),
      .ctl      (ctl),
      .shift_in (nbr),
      .entry    (entries[i]),
      .hit      (hit_vec[i])
    );
  end

endmodule
`default_nettype wire

/* hdl/krt_checker.sv */
`default_nettype none
module krt_checker
  import krt_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] status,
  input wire logic [3:0] slot_index,
  input wire logic [4:0] entry_count
);

  // a stalled response holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({status, slot_index, entry_count}))
    else $error("response changed while stalled");

  // a request occupies the block for its apply cycle
  a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted during apply cycle");

  // a full table reports the full count
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_FULL |-> entry_count == 5'(ROUTE_SLOTS))
    else $error("table full with short count");

  // failed requests touch no slot
  a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_NOT_FOUND || status == ST_FULL || status == ST_BAD_PHY)
    |-> slot_index == 4'd0)
    else $error("failed transaction reports a slot");

endmodule

bind keyed_route_table_core krt_checker u_krt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_req.valid),
  .in_ready    (in_req.ready),
  .out_valid   (out_rsp.valid),
  .out_ready   (out_rsp.ready),
  .status      (out_rsp.status),
  .slot_index  (out_rsp.slot_index),
  .entry_count (out_rsp.entry_count)
);
`default_nettype wire

/* test/keyed_route_table_core_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module keyed_route_table_core_tb;
  import krt_pkg::*;

  // request code the block leaves alone
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_REQS = 950;
  localparam int CYCLE_LIMIT = 200000;
  localparam int KEY_POOL = 24;

  typedef struct {
    logic [1:0]  req;
    logic [15:0] id;
    logic [7:0]  phy;
    logic [15:0] frame;
    logic [31:0] rate;
    logic [7:0]  metric;
    bit          wait_idle;
  } route_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot;
    logic [4:0] count;
  } route_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  krt_req_if req_ch ();
  krt_rsp_if rsp_ch ();

  keyed_route_table_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // predicted route table contents
  route_entry_t route_mem [ROUTE_SLOTS];
  int           route_fill;

  route_req_t   req_backlog [$];
  route_rsp_t   rsp_due [$];
  logic [15:0]  key_pool [KEY_POOL];
  int           n_accepted;
  int           n_checked;
  int           fail_cnt;
  int           cycle_cnt;
  logic         calm;
  logic         gap;

  // no idling on either side for a stretch of the run
  assign calm = (n_accepted >= 300) && (n_accepted < 480);

  // apply one request to the predicted table and work out its response
  function automatic route_rsp_t route_apply(route_req_t r);
    route_rsp_t rsp;
    int         hit;
    int         slot_no;
    hit = -1;
    slot_no = 0;
    rsp.status = ST_OK;
    for (int i = 0; i < route_fill; i++) begin
      if (hit < 0 && route_mem[i].key == r.id) hit = i;
    end
    case (r.req)
      REQ_ADD: begin
        if (r.phy == 8'd0) begin
          rsp.status = ST_BAD_PHY;
        end else if (hit >= 0 || route_fill < ROUTE_SLOTS) begin
          slot_no = (hit >= 0) ? hit : route_fill;
          route_mem[slot_no].key    = r.id;
          route_mem[slot_no].phy    = r.phy;
          route_mem[slot_no].frame  = r.frame;
          route_mem[slot_no].rate   = r.rate;
          route_mem[slot_no].metric = r.metric;
          if (hit < 0) route_fill++;
        end else begin
          rsp.status = ST_FULL;
        end
      end
      REQ_REMOVE: begin
        if (hit >= 0) begin
          for (int i = hit; i < route_fill - 1; i++) route_mem[i] = route_mem[i + 1];
          route_fill--;
          slot_no = hit;
        end else begin
          rsp.status = ST_NOT_FOUND;
        end
      end
      REQ_CLEAR: begin
        route_fill = 0;
      end
      default: begin
      end
    endcase
    rsp.slot  = slot_no[3:0];
    rsp.count = route_fill[4:0];
    return rsp;
  endfunction

  function automatic route_req_t make_req(logic [1:0] req, logic [15:0] id, logic [7:0] phy,
                                          logic [15:0] frame, logic [31:0] rate,
                                          logic [7:0] metric);
    route_req_t r;
    r.req = req;
    r.id = id;
    r.phy = phy;
    r.frame = frame;
    r.rate = rate;
    r.metric = metric;
    r.wait_idle = 1'b0;
    return r;
  endfunction

  // mostly keys from a small pool so updates, removes and a full table occur
  function automatic logic [15:0] pick_key();
    if ($urandom_range(99) < 80) return key_pool[$urandom_range(KEY_POOL - 1)];
    return 16'($urandom);
  endfunction

  task automatic flag(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%0t: %s", $time, msg);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      gap = !calm && ($urandom_range(99) < 38);
      if (req_backlog.size() != 0 && !gap &&
          !(req_backlog[0].wait_idle && (req_ch.valid || n_checked != n_accepted))) begin
        req_ch.req_type     <= req_backlog[0].req;
        req_ch.route_key    <= req_backlog[0].id;
        req_ch.phy_port     <= req_backlog[0].phy;
        req_ch.max_frame    <= req_backlog[0].frame;
        req_ch.read_rate    <= req_backlog[0].rate;
        req_ch.route_metric <= req_backlog[0].metric;
        req_ch.valid        <= 1'b1;
        void'(req_backlog.pop_front());
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // response backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= calm || ($urandom_range(99) >= 38);
    end
  end

  // monitor: predict on accepted requests, check accepted responses
  always @(posedge clk) begin
    route_rsp_t want;
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) begin
        rsp_due.push_back(route_apply(make_req(req_ch.req_type, req_ch.route_key,
                                               req_ch.phy_port, req_ch.max_frame,
                                               req_ch.read_rate, req_ch.route_metric)));
        n_accepted <= n_accepted + 1;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (rsp_due.size() == 0) begin
          flag("response transaction with nothing pending");
        end else begin
          want = rsp_due.pop_front();
          if (rsp_ch.status !== want.status)
            flag($sformatf("rsp %0d status exp %0d got %0d", n_checked, want.status,
                           rsp_ch.status));
          if (rsp_ch.slot_index !== want.slot)
            flag($sformatf("rsp %0d slot_index exp %0d got %0d", n_checked, want.slot,
                           rsp_ch.slot_index));
          if (rsp_ch.entry_count !== want.count)
            flag($sformatf("rsp %0d entry_count exp %0d got %0d", n_checked, want.count,
                           rsp_ch.entry_count));
          n_checked <= n_checked + 1;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("keyed_route_table_core_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int          roll;
    logic [15:0] k;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_ADD;
    req_ch.route_key = '0;
    req_ch.phy_port = '0;
    req_ch.max_frame = '0;
    req_ch.read_rate = '0;
    req_ch.route_metric = '0;
    rsp_ch.ready = 1'b0;
    route_fill = 0;
    n_accepted = 0;
    n_checked = 0;
    fail_cnt = 0;
    cycle_cnt = 0;

    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = 16'($urandom);

    // directed: bad phy and misses on an empty table, ignored request code
    req_backlog.push_back(make_req(REQ_ADD, 16'h0001, 8'h00, 16'h1234, 32'h1, 8'h1));
    req_backlog.push_back(make_req(REQ_REMOVE, 16'h0001, 8'h01, 16'h0, 32'h0, 8'h0));
    req_backlog.push_back(make_req(REQ_UNUSED, 16'h0005, 8'hFF, 16'hFFFF, 32'hFFFFFFFF,
                                   8'hFF));
    // field extremes, update of an existing key, bad phy on an existing key
    req_backlog.push_back(make_req(REQ_ADD, 16'h0000, 8'hFF, 16'hFFFF, 32'hFFFFFFFF,
                                   8'hFF));
    req_backlog.push_back(make_req(REQ_ADD, 16'hFFFF, 8'h01, 16'h0000, 32'h0, 8'h00));
    req_backlog.push_back(make_req(REQ_ADD, 16'h0000, 8'h80, 16'h5A5A, 32'hA5A5A5A5,
                                   8'h7F));
    req_backlog.push_back(make_req(REQ_ADD, 16'hFFFF, 8'h00, 16'h1, 32'h1, 8'h1));
    // fill the table, then a new key on a full table and an update while full
    for (int i = 0; i < ROUTE_SLOTS - 2; i++)
      req_backlog.push_back(make_req(REQ_ADD, 16'h0100 + 16'(i), 8'($urandom_range(255, 1)),
                                     16'($urandom), $urandom, 8'($urandom)));
    req_backlog.push_back(make_req(REQ_ADD, 16'h1234, 8'h11, 16'h40, 32'h1000, 8'h2));
    req_backlog.push_back(make_req(REQ_ADD, 16'hFFFF, 8'h22, 16'h80, 32'h2000, 8'h3));
    // removes in the middle, at the front and at the end, then a miss and a clear
    req_backlog.push_back(make_req(REQ_REMOVE, 16'h0105, 8'h0, 16'h0, 32'h0, 8'h0));
    req_backlog.push_back(make_req(REQ_REMOVE, 16'h0000, 8'h0, 16'h0, 32'h0, 8'h0));
    req_backlog.push_back(make_req(REQ_REMOVE, 16'h010D, 8'h0, 16'h0, 32'h0, 8'h0));
    req_backlog.push_back(make_req(REQ_REMOVE, 16'h0105, 8'h0, 16'h0, 32'h0, 8'h0));
    req_backlog.push_back(make_req(REQ_CLEAR, 16'hFFFF, 8'hFF, 16'hFFFF, 32'hFFFFFFFF,
                                   8'hFF));
    req_backlog.push_back(make_req(REQ_REMOVE, 16'hFFFF, 8'h0, 16'h0, 32'h0, 8'h0));

    // random traffic, mostly adds and removes on pooled keys
    for (int n = 0; n < RANDOM_REQS; n++) begin
      roll = $urandom_range(99);
      k = pick_key();
      if (roll < 4)
        req_backlog.push_back(make_req(REQ_ADD, k, 8'h00, 16'($urandom), $urandom,
                                       8'($urandom)));
      else if (roll < 54)
        req_backlog.push_back(make_req(REQ_ADD, k, 8'($urandom_range(255, 1)),
                                       16'($urandom), $urandom, 8'($urandom)));
      else if (roll < 86)
        req_backlog.push_back(make_req(REQ_REMOVE, k, 8'($urandom), 16'($urandom),
                                       $urandom, 8'($urandom)));
      else if (roll < 87)
        req_backlog.push_back(make_req(REQ_CLEAR, k, 8'($urandom), 16'($urandom),
                                       $urandom, 8'($urandom)));
      else if (roll < 91)
        req_backlog.push_back(make_req(REQ_UNUSED, k, 8'($urandom), 16'($urandom),
                                       $urandom, 8'($urandom)));
      else
        req_backlog.push_back(make_req(REQ_ADD, 16'($urandom), 8'($urandom_range(255, 1)),
                                       16'($urandom), $urandom, 8'($urandom)));
      // let the pipe drain completely before a couple of requests
      if (n == 400 || n == 800) req_backlog[req_backlog.size() - 1].wait_idle = 1'b1;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (req_backlog.size() != 0 || req_ch.valid || n_checked != n_accepted)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (fail_cnt == 0 && n_checked == n_accepted)
      $display("keyed_route_table_core_tb: PASS");
    else
      $display("keyed_route_table_core_tb: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
